// ===== hw/rtl/vec4_normalize_macros.svh =====
// Assertion macros for the vector normalisation RTL.
`ifndef VEC4_NORMALIZE_MACROS_SVH
`define VEC4_NORMALIZE_MACROS_SVH
`ifndef SYNTH
`define VN_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define VN_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define VN_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg)
`define VN_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/vn_pkg.sv =====
// Types and constants shared by the vector normalisation pipeline.
package vn_pkg;

    localparam int COMP_W = 16;
    localparam int NUM_LANES = 4;
    localparam int SQ_W = 31;
    localparam int SUM_W = 33;
    localparam int ROOT_W = 17;
    localparam int QUO_W = 15;

    typedef struct packed {
        logic signed [COMP_W-1:0] comp_x;
        logic signed [COMP_W-1:0] comp_y;
        logic signed [COMP_W-1:0] comp_z;
        logic signed [COMP_W-1:0] comp_w;
    } in_word_t;

    typedef struct packed {
        logic signed [COMP_W-1:0] unit_x;
        logic signed [COMP_W-1:0] unit_y;
        logic signed [COMP_W-1:0] unit_z;
        logic signed [COMP_W-1:0] unit_w;
        logic [ROOT_W-1:0]        magnitude;
        logic                     zero_vector;
    } out_word_t;

    typedef struct packed {
        logic              neg;
        logic [COMP_W-1:0] abs_val;
    } lane_t;

    typedef lane_t [NUM_LANES-1:0] lanes_t;

endpackage

// ===== hw/rtl/vn_sqrt.sv =====
// Pipelined floor square root, one result bit per stage, carrying the lane data alongside.
module vn_sqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [vn_pkg::SUM_W-1:0]    in_sum,
    input  vn_pkg::lanes_t              in_lanes,
    output logic                        out_valid,
    output logic [vn_pkg::ROOT_W-1:0]   out_root,
    output vn_pkg::lanes_t              out_lanes
);
    import vn_pkg::*;

    localparam int TW = SUM_W + 1;

    logic              vld_reg   [ROOT_W];
    logic [SUM_W-1:0]  rem_reg   [ROOT_W];
    logic [ROOT_W-1:0] root_reg  [ROOT_W];
    lanes_t            lanes_reg [ROOT_W];

    genvar s;
    generate
        for (s = 0; s < ROOT_W; s++) begin : g_stage
            localparam int K = ROOT_W - 1 - s;
            logic              vld_in;
            logic [SUM_W-1:0]  rem_in;
            logic [ROOT_W-1:0] root_in;
            lanes_t            lanes_in;
            logic [TW-1:0]     trial;
            logic              take;
            logic [SUM_W-1:0]  rem_next;
            logic [ROOT_W-1:0] root_next;

            if (s == 0) begin : g_first
                assign vld_in   = in_valid;
                assign rem_in   = in_sum;
                assign root_in  = '0;
                assign lanes_in = in_lanes;
            end else begin : g_rest
                assign vld_in   = vld_reg[s-1];
                assign rem_in   = rem_reg[s-1];
                assign root_in  = root_reg[s-1];
                assign lanes_in = lanes_reg[s-1];
            end

            // Adding bit K to the root grows its square by root*2^(K+1) + 2^(2K).
            assign trial     = (TW'(root_in) << (K + 1)) + (TW'(1) << (2 * K));
            assign take      = TW'(rem_in) >= trial;
            assign rem_next  = take ? (rem_in - trial[SUM_W-1:0]) : rem_in;
            assign root_next = root_in | (ROOT_W'(take) << K);

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[s] <= 1'b0;
                end else if (en) begin
                    vld_reg[s] <= vld_in;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[s]   <= rem_next;
                    root_reg[s]  <= root_next;
                    lanes_reg[s] <= lanes_in;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_lanes = lanes_reg[ROOT_W-1];

endmodule

// ===== hw/rtl/vn_div_lane.sv =====
// One divider lane: restoring division of a component size by the length, one quotient bit a stage.
module vn_div_lane (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  vn_pkg::lane_t               in_lane,
    input  logic [vn_pkg::ROOT_W-1:0]   in_mag,
    output logic                        out_valid,
    output logic                        out_neg,
    output logic [vn_pkg::QUO_W-1:0]    out_quo,
    output logic [vn_pkg::ROOT_W-1:0]   out_mag
);
    import vn_pkg::*;

    logic              vld_reg [QUO_W];
    logic              neg_reg [QUO_W];
    logic [ROOT_W-1:0] rem_reg [QUO_W];
    logic [QUO_W-1:0]  quo_reg [QUO_W];
    logic [ROOT_W-1:0] mag_reg [QUO_W];

    genvar s;
    generate
        for (s = 0; s < QUO_W; s++) begin : g_stage
            localparam int K = QUO_W - 1 - s;
            logic              vld_in;
            logic              neg_in;
            logic [ROOT_W-1:0] rem_in;
            logic [QUO_W-1:0]  quo_in;
            logic [ROOT_W-1:0] mag_in;
            logic [ROOT_W:0]   shifted;
            logic              take;
            logic [ROOT_W-1:0] rem_next;
            logic [QUO_W-1:0]  quo_next;

            if (s == 0) begin : g_first
                // The component never exceeds the length, so the integer bit comes first.
                assign vld_in  = in_valid;
                assign neg_in  = in_lane.neg;
                assign rem_in  = ROOT_W'(in_lane.abs_val);
                assign quo_in  = '0;
                assign mag_in  = in_mag;
                assign shifted = (ROOT_W + 1)'(rem_in);
            end else begin : g_rest
                assign vld_in  = vld_reg[s-1];
                assign neg_in  = neg_reg[s-1];
                assign rem_in  = rem_reg[s-1];
                assign quo_in  = quo_reg[s-1];
                assign mag_in  = mag_reg[s-1];
                assign shifted = {rem_in, 1'b0};
            end

            assign take     = shifted >= (ROOT_W + 1)'(mag_in);
            assign rem_next = take ? ROOT_W'(shifted - (ROOT_W + 1)'(mag_in))
                                   : ROOT_W'(shifted);
            assign quo_next = quo_in | (QUO_W'(take) << K);

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[s] <= 1'b0;
                end else if (en) begin
                    vld_reg[s] <= vld_in;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    neg_reg[s] <= neg_in;
                    rem_reg[s] <= rem_next;
                    quo_reg[s] <= quo_next;
                    mag_reg[s] <= mag_in;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[QUO_W-1];
    assign out_neg   = neg_reg[QUO_W-1];
    assign out_quo   = quo_reg[QUO_W-1];
    assign out_mag   = mag_reg[QUO_W-1];

endmodule

// ===== hw/rtl/vec4_normalize.sv =====
// Top level of the four-component vector normaliser: squares, length, divider lanes, output.
//
// The block takes one vector word on the s_ channel (s_valid, s_ready, s_data) and returns
// one result word on the m_ channel (m_valid, m_ready, m_data) for every vector taken.
// Components are signed Q3.12; the result carries the length in unsigned Q5.12 (floor of
// the square root of the sum of squares), the four components divided by that length in
// signed Q1.14 truncated towards zero, and a flag for the all-zero vector, whose unit
// fields read as zero.
// The datapath is a single pipeline: squaring, summing, a 17-stage square root that yields
// one root bit per stage, then four divider lanes of 15 stages each that yield one quotient
// bit per stage, and a merging stage that restores signs into the output register.
// One word can be accepted in every cycle while the skid register is empty, so the
// sustained rate is one word per clock as long as the receiver does not stall.
// When the receiver stalls, the word leaving the pipeline is parked in a one-word skid
// register and the whole pipeline then holds; s_ready is driven from that skid register
// alone, so it never depends combinationally on m_ready.
// Reset (aresetn low at a clock edge) empties every pipeline stage, the skid register and
// the output register; no result is in flight afterwards.
`include "vec4_normalize_macros.svh"

module vec4_normalize (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  vn_pkg::in_word_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output vn_pkg::out_word_t m_data
);
    import vn_pkg::*;

    logic en;

    // Stage A: the accepted word.
    logic     a_vld_reg;
    in_word_t a_data_reg;
    logic signed [COMP_W-1:0] a_comp [NUM_LANES];

    // Stage B: squares, signs and sizes.
    logic              b_vld_reg;
    logic [SQ_W-1:0]   b_sq_reg [NUM_LANES];
    lanes_t            b_lanes_reg;
    lanes_t            b_lanes_next;

    // Stage C: the sum of squares.
    logic              c_vld_reg;
    logic [SUM_W-1:0]  c_sum_reg;
    lanes_t            c_lanes_reg;

    // Square root outputs.
    logic              r_vld;
    logic [ROOT_W-1:0] r_root;
    lanes_t            r_lanes;

    // Divider lane outputs.
    logic              d_vld [NUM_LANES];
    logic              d_neg [NUM_LANES];
    logic [QUO_W-1:0]  d_quo [NUM_LANES];
    logic [ROOT_W-1:0] d_mag [NUM_LANES];
    logic signed [COMP_W-1:0] d_unit [NUM_LANES];

    out_word_t merged;
    logic      m_valid_reg;
    out_word_t m_data_reg;
    logic      skid_full_reg;
    out_word_t skid_data_reg;

    // The pipeline moves whenever the skid register is free to catch what leaves it.
    assign en      = !skid_full_reg;
    assign s_ready = en;

    assign a_comp[0] = a_data_reg.comp_x;
    assign a_comp[1] = a_data_reg.comp_y;
    assign a_comp[2] = a_data_reg.comp_z;
    assign a_comp[3] = a_data_reg.comp_w;

    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            b_lanes_next[i].neg     = a_comp[i][COMP_W-1];
            b_lanes_next[i].abs_val = a_comp[i][COMP_W-1] ? (~a_comp[i] + COMP_W'(1))
                                                          : a_comp[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg <= s_valid;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_data_reg  <= s_data;
            for (int i = 0; i < NUM_LANES; i++) begin
                b_sq_reg[i] <= SQ_W'(a_comp[i] * a_comp[i]);
            end
            b_lanes_reg <= b_lanes_next;
            c_sum_reg   <= SUM_W'(b_sq_reg[0]) + SUM_W'(b_sq_reg[1])
                         + SUM_W'(b_sq_reg[2]) + SUM_W'(b_sq_reg[3]);
            c_lanes_reg <= b_lanes_reg;
        end
    end

    vn_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (c_vld_reg),
        .in_sum    (c_sum_reg),
        .in_lanes  (c_lanes_reg),
        .out_valid (r_vld),
        .out_root  (r_root),
        .out_lanes (r_lanes)
    );

    genvar g;
    generate
        for (g = 0; g < NUM_LANES; g++) begin : g_lane
            vn_div_lane u_div (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .en        (en),
                .in_valid  (r_vld),
                .in_lane   (r_lanes[g]),
                .in_mag    (r_root),
                .out_valid (d_vld[g]),
                .out_neg   (d_neg[g]),
                .out_quo   (d_quo[g]),
                .out_mag   (d_mag[g])
            );

            // A zero length leaves the lane's quotient meaningless, so it is forced to zero.
            assign d_unit[g] = (d_mag[g] == '0) ? '0
                             : d_neg[g] ? (COMP_W'(0) - COMP_W'(d_quo[g]))
                             : COMP_W'(d_quo[g]);
        end
    endgenerate

    // Merging stage: all lanes run in lockstep, so lane 0 speaks for the valid and length.
    always_comb begin
        merged.unit_x      = d_unit[0];
        merged.unit_y      = d_unit[1];
        merged.unit_z      = d_unit[2];
        merged.unit_w      = d_unit[3];
        merged.magnitude   = d_mag[0];
        merged.zero_vector = (d_mag[0] == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg   <= 1'b0;
            skid_full_reg <= 1'b0;
        end else if (skid_full_reg) begin
            if (m_ready) begin
                skid_full_reg <= 1'b0;
            end
        end else if (d_vld[0]) begin
            if (!m_valid_reg || m_ready) begin
                m_valid_reg <= 1'b1;
            end else begin
                skid_full_reg <= 1'b1;
            end
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_full_reg) begin
            if (m_ready) begin
                m_data_reg <= skid_data_reg;
            end
        end else if (d_vld[0]) begin
            if (!m_valid_reg || m_ready) begin
                m_data_reg <= merged;
            end else begin
                skid_data_reg <= merged;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `VN_ASSERT_NOW(a_skid_behind_out, aclk, aresetn, skid_full_reg, m_valid_reg,
        "skid register holds a word while the output register is empty")
    `VN_ASSERT_NXT(a_skid_holds, aclk, aresetn, skid_full_reg && !m_ready,
        skid_full_reg && $stable(skid_data_reg) && $stable(m_data_reg),
        "parked word changed while the receiver stalled")
    `VN_ASSERT_NOW(a_zero_clean, aclk, aresetn, m_valid_reg && m_data_reg.zero_vector,
        (m_data_reg.magnitude == '0) && (m_data_reg.unit_x == '0) &&
        (m_data_reg.unit_y == '0) && (m_data_reg.unit_z == '0) &&
        (m_data_reg.unit_w == '0),
        "zero vector result carries a non-zero field")

endmodule

// ===== tb/vec4_normalize_tb.sv =====
// Self-checking testbench for the four-component vector normaliser.
module vec4_normalize_tb;

    import vn_pkg::*;

    // Length of the final drain, counted once every expected result has been seen.
    localparam int DRAIN_CYCLES = 80;
    // Cycles without any accepted word before the run is abandoned.
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_WORDS = 1630;
    localparam int N_DIRECTED   = 18;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_data;

    out_word_t norm_pending[$];
    int        fail_count;
    bit        stim_done;
    bit        calm_phase;
    bit        long_hold;

    // One row of the directed table: the vector and, where it can be read at a glance,
    // the result that it must give.
    typedef struct {
        in_word_t  vec;
        bit        typed;
        out_word_t res;
    } dir_row_t;

    dir_row_t dir_rows[N_DIRECTED];

    vec4_normalize i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Floor square root of a 33-bit sum, one result bit at a time from the top.
    function automatic logic [16:0] floor_root(logic [32:0] sum);
        logic [16:0] root;
        logic [16:0] trial;
        root = '0;
        for (int b = 16; b >= 0; b--) begin
            trial = root | (17'd1 << b);
            if ({17'd0, trial} * {17'd0, trial} <= {1'b0, sum})
                root = trial;
        end
        return root;
    endfunction

    // One component divided by the length, in Q1.14, truncated towards zero.
    function automatic logic signed [15:0] unit_lane(logic signed [15:0] c,
                                                     logic [16:0] len);
        logic [16:0] mag_c;
        logic [31:0] quo;
        if (len == 0)
            return '0;
        mag_c = c[15] ? 17'(-int'(c)) : 17'(c);
        quo   = ({15'd0, mag_c} << 14) / {15'd0, len};
        return c[15] ? 16'(-quo) : 16'(quo);
    endfunction

    function automatic out_word_t normalise_vec(in_word_t v);
        out_word_t   r;
        logic [32:0] sum;
        sum = 33'(longint'(v.comp_x) * v.comp_x) + 33'(longint'(v.comp_y) * v.comp_y)
            + 33'(longint'(v.comp_z) * v.comp_z) + 33'(longint'(v.comp_w) * v.comp_w);
        r.magnitude   = floor_root(sum);
        r.zero_vector = (r.magnitude == 0);
        r.unit_x      = unit_lane(v.comp_x, r.magnitude);
        r.unit_y      = unit_lane(v.comp_y, r.magnitude);
        r.unit_z      = unit_lane(v.comp_z, r.magnitude);
        r.unit_w      = unit_lane(v.comp_w, r.magnitude);
        return r;
    endfunction

    function automatic in_word_t mk_vec(int x, int y, int z, int w);
        in_word_t v;
        v.comp_x = 16'(x);
        v.comp_y = 16'(y);
        v.comp_z = 16'(z);
        v.comp_w = 16'(w);
        return v;
    endfunction

    function automatic out_word_t mk_res(int ux, int uy, int uz, int uw, int mag, bit zf);
        out_word_t r;
        r.unit_x      = 16'(ux);
        r.unit_y      = 16'(uy);
        r.unit_z      = 16'(uz);
        r.unit_w      = 16'(uw);
        r.magnitude   = 17'(mag);
        r.zero_vector = zf;
        return r;
    endfunction

    // Random vectors: mostly full range, some small, some near the extremes, since the
    // square root and the dividers behave differently at each end of the range.
    function automatic in_word_t rand_vec();
        in_word_t v;
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        v = raw;
        case ($urandom_range(0, 7))
            0: begin
                v.comp_x = $signed(16'($urandom_range(0, 15))) - 16'sd8;
                v.comp_y = $signed(16'($urandom_range(0, 15))) - 16'sd8;
                v.comp_z = $signed(16'($urandom_range(0, 15))) - 16'sd8;
                v.comp_w = $signed(16'($urandom_range(0, 15))) - 16'sd8;
            end
            1: begin
                v.comp_x = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
                v.comp_y = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            end
            2: begin
                v.comp_y = '0;
                v.comp_z = '0;
                v.comp_w = $urandom_range(0, 3) == 0 ? v.comp_w : '0;
            end
            3: begin
                v = '0;
            end
            default: ;
        endcase
        return v;
    endfunction

    // The directed table. Rows that carry a typed result are checked against it as well as
    // against the predictor, so that a mistake in either shows.
    initial begin
        dir_rows[0]  = '{mk_vec(0, 0, 0, 0), 1'b1, mk_res(0, 0, 0, 0, 0, 1'b1)};
        dir_rows[1]  = '{mk_vec(4096, 0, 0, 0), 1'b1, mk_res(16384, 0, 0, 0, 4096, 1'b0)};
        dir_rows[2]  = '{mk_vec(0, -4096, 0, 0), 1'b1, mk_res(0, -16384, 0, 0, 4096, 1'b0)};
        dir_rows[3]  = '{mk_vec(0, 0, 1, 0), 1'b1, mk_res(0, 0, 16384, 0, 1, 1'b0)};
        dir_rows[4]  = '{mk_vec(0, 0, 0, -1), 1'b1, mk_res(0, 0, 0, -16384, 1, 1'b0)};
        dir_rows[5]  = '{mk_vec(-32768, -32768, -32768, -32768), 1'b1,
                         mk_res(-8192, -8192, -8192, -8192, 65536, 1'b0)};
        dir_rows[6]  = '{mk_vec(-32768, 0, 0, 0), 1'b1, mk_res(-16384, 0, 0, 0, 32768, 1'b0)};
        dir_rows[7]  = '{mk_vec(32767, 32767, 32767, 32767), 1'b1,
                         mk_res(8192, 8192, 8192, 8192, 65534, 1'b0)};
        dir_rows[8]  = '{mk_vec(0, 0, 0, 32767), 1'b1, mk_res(0, 0, 0, 16384, 32767, 1'b0)};
        dir_rows[9]  = '{mk_vec(32767, -32768, 32767, -32768), 1'b0, '0};
        dir_rows[10] = '{mk_vec(1, 1, 1, 1), 1'b1, mk_res(8192, 8192, 8192, 8192, 2, 1'b0)};
        dir_rows[11] = '{mk_vec(-1, -1, -1, -1), 1'b1,
                         mk_res(-8192, -8192, -8192, -8192, 2, 1'b0)};
        dir_rows[12] = '{mk_vec(3, 4, 0, 0), 1'b1, mk_res(9830, 13107, 0, 0, 5, 1'b0)};
        dir_rows[13] = '{mk_vec(1, 1, 0, 0), 1'b0, '0};
        dir_rows[14] = '{mk_vec(12288, -16384, 0, 0), 1'b0, '0};
        dir_rows[15] = '{mk_vec(-21846, 21845, -1, 1), 1'b0, '0};
        dir_rows[16] = '{mk_vec(0, 0, 0, 0), 1'b1, mk_res(0, 0, 0, 0, 0, 1'b1)};
        dir_rows[17] = '{mk_vec(21845, -21846, 21845, -21846), 1'b0, '0};
    end

    // Sender: offers each vector and holds it until accepted, with random bursts of idling.
    task automatic send_vec(in_word_t v);
        if (!calm_phase && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= v;
        norm_pending.push_back(normalise_vec(v));
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    initial begin
        in_word_t  v;
        out_word_t typed_res;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        stim_done  = 1'b0;
        calm_phase = 1'b0;
        long_hold  = 1'b0;
        fail_count = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            if (dir_rows[i].typed) begin
                typed_res = normalise_vec(dir_rows[i].vec);
                if (typed_res != dir_rows[i].res) begin
                    $error("predictor row %0d: expected %h, predicted %h",
                           i, dir_rows[i].res, typed_res);
                    fail_count++;
                end
            end
            send_vec(dir_rows[i].vec);
        end

        for (int i = 0; i < RANDOM_WORDS; i++) begin
            // A long hold on the result side early on fills the pipeline and stalls input.
            if (i == 200)
                long_hold <= 1'b1;
            if (i >= RANDOM_WORDS - 200)
                calm_phase <= 1'b1;
            v = rand_vec();
            send_vec(v);
        end
        s_valid   <= 1'b0;
        stim_done <= 1'b1;
    end

    // Receiver: random stall bursts, one long hold, and none in the calm final part.
    initial begin
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (long_hold) begin
                m_ready <= 1'b0;
                repeat (120) @(posedge aclk);
                long_hold <= 1'b0;
            end else if (!calm_phase && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Result checker: compares every accepted word with the oldest expectation.
    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (norm_pending.size() == 0) begin
                $error("result word with no vector outstanding: %h", m_data);
                fail_count++;
            end else begin
                want = norm_pending.pop_front();
                if (m_data.unit_x != want.unit_x) begin
                    $error("unit_x: expected %0d, actual %0d", want.unit_x, m_data.unit_x);
                    fail_count++;
                end
                if (m_data.unit_y != want.unit_y) begin
                    $error("unit_y: expected %0d, actual %0d", want.unit_y, m_data.unit_y);
                    fail_count++;
                end
                if (m_data.unit_z != want.unit_z) begin
                    $error("unit_z: expected %0d, actual %0d", want.unit_z, m_data.unit_z);
                    fail_count++;
                end
                if (m_data.unit_w != want.unit_w) begin
                    $error("unit_w: expected %0d, actual %0d", want.unit_w, m_data.unit_w);
                    fail_count++;
                end
                if (m_data.magnitude != want.magnitude) begin
                    $error("magnitude: expected %0d, actual %0d",
                           want.magnitude, m_data.magnitude);
                    fail_count++;
                end
                if (m_data.zero_vector != want.zero_vector) begin
                    $error("zero_vector: expected %0d, actual %0d",
                           want.zero_vector, m_data.zero_vector);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog and end of run. The watchdog counts cycles in which no word moves on
    // either channel; the drain wait counts once every vector is in and every result is out.
    initial begin
        int idle_cycles;
        int drained;
        idle_cycles = 0;
        drained     = 0;
        @(posedge aclk iff aresetn);
        while (drained < DRAIN_CYCLES && idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (stim_done && norm_pending.size() == 0)
                drained++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
        end else if (fail_count == 0 && norm_pending.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/vn_pkg.sv
hw/rtl/vn_sqrt.sv
hw/rtl/vn_div_lane.sv
hw/rtl/vec4_normalize.sv
tb/vec4_normalize_tb.sv
